>>> rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table: request and result
// words, controller command and status groups, and saturation limits.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CAP_W   = 5;

  localparam logic       OP_GET = 1'b0;
  localparam logic       OP_PUT = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
  localparam logic [STAMP_W-1:0] STAMP_MAX  = {STAMP_W{1'b1}};
  localparam logic [VAL_W-1:0]   MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0]   PUT_VALUE  = '0;
  localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
  } lfu_req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } lfu_rsp_t;

  typedef struct packed {
    logic load;    // capture the request and clear the scan results
    logic scan;    // read the entry at the scan index and advance it
    logic update;  // write the table and issue the result
  } lfu_cmd_t;

  typedef struct packed {
    logic empty;      // no entry is occupied
    logic scan_last;  // scan index is at the last occupied entry
  } lfu_stat_t;

endpackage

>>> rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for one cache operation: capture, scan of the occupied
// entries, pipeline drain, and the table update.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  lfu_stat_t stat,
  output lfu_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = stat.empty ? S_UPDATE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy       = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && start;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.update = (state == S_UPDATE);

endmodule

>>> rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry storage, the sequential key match and victim search, the capacity
// register, and the update that writes one slot per operation.
// ----------------------------------------------------------------------------
module lfu_datapath
  import lfu_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  lfu_cmd_t         cmd,
  output lfu_stat_t        stat,
  input  lfu_req_t         request,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output lfu_rsp_t         result,
  output logic             done
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Slots fill from the bottom and are never freed, so the occupied
  // entries are always slots 0 to occupied-1.
  logic [KEY_W-1:0]   key_mem   [CAPACITY];
  logic [VAL_W-1:0]   val_mem   [CAPACITY];
  logic [COUNT_W-1:0] cnt_mem   [CAPACITY];
  logic [STAMP_W-1:0] stamp_mem [CAPACITY];

  logic [OCC_W-1:0]   occupied;
  logic [CAP_W-1:0]   capacity;
  logic [STAMP_W-1:0] stamp_counter;
  logic [IDX_W-1:0]   idx;
  lfu_req_t           req;

  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic [COUNT_W-1:0] rd_cnt;
  logic [STAMP_W-1:0] rd_stamp;

  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic [VAL_W-1:0]   match_val;
  logic [COUNT_W-1:0] match_cnt;
  logic               vict_found;
  logic [IDX_W-1:0]   vict_idx;
  logic [COUNT_W-1:0] vict_cnt;
  logic [STAMP_W-1:0] vict_stamp;

  logic               key_eq;
  logic               better;
  logic               is_put;
  logic               limit_zero;
  logic               free_slot;
  logic               bump_do;
  logic               new_do;
  logic               val_we;
  logic [IDX_W-1:0]   wr_slot;
  logic [OCC_W-1:0]   occ_m1;

  assign occ_m1         = occupied - OCC_W'(1);
  assign stat.empty     = (occupied == '0);
  assign stat.scan_last = (OCC_W'(idx) == occ_m1);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  // Scan index and read pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.scan) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_idx   <= idx;
      rd_key   <= key_mem[idx];
      rd_val   <= val_mem[idx];
      rd_cnt   <= cnt_mem[idx];
      rd_stamp <= stamp_mem[idx];
    end
  end

  // The first matching key wins; the victim is the lowest count, then the
  // oldest stamp, with ties kept at the lower slot.
  assign key_eq = (rd_key == req.lookup_key);
  assign better = !vict_found || (rd_cnt < vict_cnt) ||
                  ((rd_cnt == vict_cnt) && (rd_stamp < vict_stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      vict_found  <= 1'b0;
    end else if (cmd.load) begin
      match_found <= 1'b0;
      vict_found  <= 1'b0;
    end else if (rd_vld) begin
      if (!match_found && key_eq) begin
        match_found <= 1'b1;
      end
      if (better) begin
        vict_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && !match_found && key_eq) begin
      match_idx <= rd_idx;
      match_val <= rd_val;
      match_cnt <= rd_cnt;
    end
    if (rd_vld && better) begin
      vict_idx   <= rd_idx;
      vict_cnt   <= rd_cnt;
      vict_stamp <= rd_stamp;
    end
  end

  // Update decisions.
  assign is_put     = (req.opcode == OP_PUT);
  assign limit_zero = (capacity == '0);
  assign free_slot  = (LIM_W'(occupied) < LIM_W'(capacity)) &&
                      (LIM_W'(occupied) < LIM_W'(CAPACITY));
  assign bump_do    = match_found && (!is_put || !limit_zero) && (match_cnt != COUNT_MAX);
  assign new_do     = is_put && !limit_zero && !match_found;
  assign val_we     = is_put && !limit_zero;

  always_comb begin
    priority if (match_found) begin
      wr_slot = match_idx;
    end else if (free_slot) begin
      wr_slot = occupied[IDX_W-1:0];
    end else begin
      wr_slot = vict_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (new_do) begin
        key_mem[wr_slot] <= req.lookup_key;
      end
      if (val_we) begin
        val_mem[wr_slot] <= req.store_value;
      end
      if (new_do) begin
        cnt_mem[wr_slot]   <= COUNT_ONE;
        stamp_mem[wr_slot] <= stamp_counter;
      end else if (bump_do) begin
        cnt_mem[wr_slot]   <= match_cnt + COUNT_ONE;
        stamp_mem[wr_slot] <= stamp_counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied      <= '0;
      stamp_counter <= '0;
      done          <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        if (new_do && free_slot) begin
          occupied <= occupied + OCC_W'(1);
        end
        if ((new_do || bump_do) && (stamp_counter != STAMP_MAX)) begin
          stamp_counter <= stamp_counter + STAMP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.hit <= match_found;
      if (is_put) begin
        result.read_value <= PUT_VALUE;
      end else if (match_found) begin
        result.read_value <= match_val;
      end else begin
        result.read_value <= MISS_VALUE;
      end
    end
  end

endmodule

>>> rtl/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Sequence: after start is taken, capture, one read per occupied entry,
// drain, then update, after which done strobes; an empty table skips scan
// and drain. busy is high through scan, drain and update, so a new request
// is taken only while busy is low.
// Reset empties the table and loads capacity 16; results cannot be stalled.
// ----------------------------------------------------------------------------
module lfu_cache_table_core
  import lfu_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  lfu_req_t         request,
  output lfu_rsp_t         result,
  output logic             done,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lfu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .request  (request),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (result),
    .done     (done)
  );

endmodule
